@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the core port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check at every clock edge outside reset
`define UVS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uvs: property failed");
// Check at every clock edge, reset included
`define UVS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("uvs: property failed");
`endif

@@ rtl/core/uvs_pkg.sv @@
// Types, constants and helper functions of the UV sphere tessellator core
`timescale 1ns / 1ps
package uvs_pkg;
  localparam int MAX_STACKS = 64;
  localparam int MAX_SLICES = 64;
  localparam int FRAC_BITS  = 14;
  localparam int ONE_Q      = 1 << FRAC_BITS;
  localparam int SIN_SH     = 30 - FRAC_BITS;

  localparam int EW = 13;

  localparam int DIV_NW = 24;
  localparam int DIV_QW = 17;
  localparam int DIV_DW = 8;

  localparam int SIN_LAT  = 7;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [1:0] ST_MORE    = 2'd0;
  localparam logic [1:0] ST_LAST    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] REG_STACKS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [1:0] LAST_IDX = 2'd2;
  localparam logic [15:0] QTURN   = 16'h4000;

  localparam logic signed [15:0] Q_ONE = 16'(ONE_Q);
  localparam logic [14:0] TEX_ONE  = 15'(ONE_Q);
  localparam logic [14:0] TEX_HALF = 15'(ONE_Q / 2);

  localparam logic [30:0] SIN_C [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                        31'd693598668, 31'd1686629713};

  typedef enum logic [2:0] {K_VERT, K_TOP, K_BOT, K_CAP, K_BAND, K_BAD} kind_t;

  typedef struct packed {
    logic [6:0]  stacks;
    logic [6:0]  slices;
    logic [14:0] radius;
  } cfg_t;

  typedef struct packed {
    kind_t                 kind;
    logic [EW-1:0]         num;
    logic                  odd;
    logic [2:0][EW-1:0]    corner;
    logic [14:0]           tu;
    logic [14:0]           tv;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_z;
  } vtx_t;

  function automatic logic signed [15:0] mulq(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    logic        neg;
    logic [15:0] ua;
    logic [15:0] ub;
    logic [31:0] m;
    neg = a[15] ^ b[15];
    ua  = a[15] ? 16'(-a) : 16'(a);
    ub  = b[15] ? 16'(-b) : 16'(b);
    m   = (32'(ua) * 32'(ub) + 32'(ONE_Q / 2)) >> FRAC_BITS;
    return neg ? -$signed(m[15:0]) : $signed(m[15:0]);
  endfunction
endpackage

@@ rtl/core/uvs_if.sv @@
// Request and result channel interfaces of the tessellator core
`timescale 1ns / 1ps
interface uvs_req_if;
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [uvs_pkg::EW-1:0] element_number;
  modport source (output valid, cmd, element_number, input ready);
  modport sink (input valid, cmd, element_number, output ready);
endinterface

interface uvs_res_if;
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     pos_x;
  logic signed [15:0]     pos_y;
  logic signed [15:0]     pos_z;
  logic [14:0]            tex_u;
  logic [14:0]            tex_v;
  logic signed [15:0]     norm_x;
  logic signed [15:0]     norm_y;
  logic signed [15:0]     norm_z;
  logic signed [15:0]     tan_x;
  logic signed [15:0]     tan_z;
  logic [uvs_pkg::EW-1:0] vertex_ref;
  logic [1:0]             status;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                  norm_z, tan_x, tan_z, vertex_ref, status, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                norm_z, tan_x, tan_z, vertex_ref, status, output ready);
endinterface

@@ rtl/core/uvs_regs.sv @@
// APB configuration registers with saturated effective values
`timescale 1ns / 1ps
module uvs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uvs_pkg::APB_AW-1:0]  paddr,
  input  logic [uvs_pkg::APB_DW-1:0]  pwdata,
  output logic [uvs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output uvs_pkg::cfg_t               cfg
);
  import uvs_pkg::*;

  logic [6:0]  stack_rows;
  logic [6:0]  slice_columns;
  logic [14:0] sphere_radius;
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[APB_AW-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_rows    <= 7'd20;
      slice_columns <= 7'd20;
      sphere_radius <= 15'd8192;
    end else if (wr) begin
      case (idx)
        REG_STACKS: stack_rows    <= pwdata[6:0];
        REG_SLICES: slice_columns <= pwdata[6:0];
        REG_RADIUS: sphere_radius <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STACKS: prdata = APB_DW'(stack_rows);
      REG_SLICES: prdata = APB_DW'(slice_columns);
      REG_RADIUS: prdata = APB_DW'(sphere_radius);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.stacks = stack_rows < 7'd2 ? 7'd2 :
                 (stack_rows > 7'(MAX_STACKS) ? 7'(MAX_STACKS) : stack_rows);
    cfg.slices = slice_columns < 7'd3 ? 7'd3 :
                 (slice_columns > 7'(MAX_SLICES) ? 7'(MAX_SLICES) : slice_columns);
    cfg.radius = sphere_radius > 15'(ONE_Q) ? 15'(ONE_Q) : sphere_radius;
  end
endmodule

@@ rtl/core/uvs_front.sv @@
// Request classifier: range checks, pole and cap decode, band offsets
`timescale 1ns / 1ps
module uvs_front (
  input  uvs_pkg::cfg_t  cfg,
  uvs_req_if.sink        req,
  input  logic           full,
  output logic           push,
  output uvs_pkg::item_t item
);
  import uvs_pkg::*;

  logic [6:0]    ring;
  logic [13:0]   vprod;
  logic [13:0]   tprod;
  logic [13:0]   bprod;
  logic [EW-1:0] nvert;
  logic [EW-1:0] ntri;
  logic [EW-1:0] nband;
  logic [EW-1:0] e;
  logic [EW-1:0] t;
  logic [EW-1:0] i;
  logic [EW-1:0] bottom;
  logic [EW-1:0] last;

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    ring   = cfg.slices + 7'd1;
    vprod  = 14'(cfg.stacks - 7'd1) * 14'(ring);
    tprod  = 14'(cfg.slices) * 14'(cfg.stacks - 7'd1);
    bprod  = 14'(cfg.slices) * 14'(cfg.stacks - 7'd2);
    nvert  = EW'(vprod) + 13'd2;
    ntri   = EW'({tprod, 1'b0});
    nband  = EW'({bprod, 1'b0});
    e      = req.element_number;
    t      = e - EW'(cfg.slices);
    i      = t - nband;
    bottom = nvert - 13'd1;
    last   = bottom - EW'(ring);
    item   = '0;
    item.kind = K_BAD;
    if (!req.cmd) begin
      if (e >= nvert) begin
        item.kind = K_BAD;
      end else if (e == '0) begin
        item.kind = K_TOP;
      end else if (e == bottom) begin
        item.kind = K_BOT;
      end else begin
        item.kind = K_VERT;
        item.num  = e - 13'd1;
      end
    end else begin
      if (e >= ntri) begin
        item.kind = K_BAD;
      end else if (e < EW'(cfg.slices)) begin
        item.kind      = K_CAP;
        item.corner[0] = '0;
        item.corner[1] = e + 13'd2;
        item.corner[2] = e + 13'd1;
      end else if (t < nband) begin
        item.kind = K_BAND;
        item.num  = t >> 1;
        item.odd  = t[0];
      end else begin
        item.kind      = K_CAP;
        item.corner[0] = bottom;
        item.corner[1] = last + i;
        item.corner[2] = last + i + 13'd1;
      end
    end
  end
endmodule

@@ rtl/core/uvs_fifo.sv @@
// Short word queue between the classifier and the generator pipeline
`timescale 1ns / 1ps
module uvs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  uvs_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output uvs_pkg::item_t dout,
  output logic           empty
);
  import uvs_pkg::*;

  item_t            mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wp;
  logic [FQ_AW-1:0] rp;
  logic [FQ_AW:0]   cnt;

  assign full  = cnt == (FQ_AW + 1)'(FQ_DEPTH);
  assign empty = cnt == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end
endmodule

@@ rtl/core/uvs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module uvs_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [uvs_pkg::DIV_NW-1:0] num,
  input  logic [uvs_pkg::DIV_DW-1:0] den,
  output logic [uvs_pkg::DIV_QW-1:0] quo,
  output logic [uvs_pkg::DIV_DW-1:0] rem
);
  import uvs_pkg::*;

  logic [DIV_DW-1:0] rem_r [DIV_QW];
  logic [DIV_QW-1:0] low_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];

  logic [DIV_DW-1:0] s_rem [DIV_QW];
  logic [DIV_QW-1:0] s_low [DIV_QW];
  logic [DIV_QW-1:0] s_quo [DIV_QW];
  logic [DIV_DW-1:0] s_den [DIV_QW];
  logic [DIV_DW:0]   trial [DIV_QW];
  logic              ge    [DIV_QW];

  always_comb begin
    for (int j = 0; j < DIV_QW; j++) begin
      if (j == 0) begin
        s_rem[j] = DIV_DW'(num[DIV_NW-1:DIV_QW]);
        s_low[j] = num[DIV_QW-1:0];
        s_quo[j] = '0;
        s_den[j] = den;
      end else begin
        s_rem[j] = rem_r[j-1];
        s_low[j] = low_r[j-1];
        s_quo[j] = quo_r[j-1];
        s_den[j] = den_r[j-1];
      end
      trial[j] = {s_rem[j], s_low[j][DIV_QW-1]};
      ge[j]    = trial[j] >= {1'b0, s_den[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_QW; j++) begin
        rem_r[j] <= ge[j] ? DIV_DW'(trial[j] - {1'b0, s_den[j]}) : trial[j][DIV_DW-1:0];
        low_r[j] <= s_low[j] << 1;
        quo_r[j] <= {s_quo[j][DIV_QW-2:0], ge[j]};
        den_r[j] <= s_den[j];
      end
    end
  end

  assign quo = quo_r[DIV_QW-1];
  assign rem = rem_r[DIV_QW-1];
endmodule

@@ rtl/core/uvs_sin.sv @@
// Pipelined sine of a 16-bit turn fraction, Horner polynomial in Q30
`timescale 1ns / 1ps
module uvs_sin (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        ang,
  output logic signed [15:0] val
);
  import uvs_pkg::*;

  logic [14:0] t_r  [5];
  logic [1:0]  q_r  [6];
  logic [14:0] t2_r [4];
  logic [30:0] p_r  [5];
  logic [31:0] v_r;

  logic [14:0] t0;
  logic [29:0] tt;
  logic [45:0] hp [5];
  logic [30:0] hn [5];
  logic [45:0] vp;
  logic [31:0] vc;
  logic [31:0] vm;

  always_comb begin
    t0 = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    tt = 30'(t0) * 30'(t0) + 30'd8192;
    hp[0] = '0;
    hn[0] = SIN_C[0];
    for (int j = 1; j < 5; j++) begin
      hp[j] = 46'(t2_r[j-1]) * 46'(p_r[j-1]) + 46'd8192;
      hn[j] = 31'(32'(SIN_C[j]) - hp[j][45:14]);
    end
    vp = 46'(t_r[4]) * 46'(p_r[4]) + 46'd8192;
    vc = v_r > 32'h4000_0000 ? 32'h4000_0000 : v_r;
    vm = (vc + 32'(1 << (SIN_SH - 1))) >> SIN_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]  <= t0;
      q_r[0]  <= ang[15:14];
      t2_r[0] <= tt[28:14];
      p_r[0]  <= hn[0];
      for (int j = 1; j < 5; j++) begin
        t_r[j] <= t_r[j-1];
        q_r[j] <= q_r[j-1];
        p_r[j] <= hn[j];
      end
      for (int j = 1; j < 4; j++) begin
        t2_r[j] <= t2_r[j-1];
      end
      v_r    <= vp[45:14];
      q_r[5] <= q_r[4];
      val    <= q_r[5][1] ? -$signed(16'(vm)) : $signed(16'(vm));
    end
  end
endmodule

@@ rtl/core/uvs_back.sv @@
// Generator pipeline: row and column split, angles, trig, products, word output
`timescale 1ns / 1ps
module uvs_back (
  input  logic           clk,
  input  logic           rst,
  input  uvs_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  uvs_pkg::item_t head,
  output logic           pop,
  uvs_res_if.source      res
);
  import uvs_pkg::*;

  logic adv;

  logic              d1_v [DIV_QW];
  item_t             d1_s [DIV_QW];
  logic [DIV_QW-1:0] d1_quo;
  logic [DIV_DW-1:0] d1_rem;
  logic [DIV_DW-1:0] d1_den;
  logic [6:0]        ring;

  logic [6:0]        row0;
  logic [6:0]        col;
  logic [6:0]        row;
  logic [13:0]       aprod;
  logic [EW-1:0]     ca;
  logic [EW-1:0]     cb;
  item_t             p1_n;

  logic              p1_v;
  item_t             p1_s;
  logic [DIV_NW-1:0] p1_num [4];
  logic [DIV_DW-1:0] p1_den [4];
  logic [DIV_QW-1:0] d2_quo [4];

  logic              d2_v [DIV_QW];
  item_t             d2_s [DIV_QW];
  item_t             d2_n;

  logic              s_v [SIN_LAT];
  item_t             s_s [SIN_LAT];
  logic signed [15:0] sp, cp, st, ct;

  logic              m1_v;
  item_t             m1_s;
  logic signed [15:0] nx, ny, nz, tx, tz;

  logic signed [15:0] rad;
  logic              m2_v;
  logic              m2_tri;
  logic [2:0][EW-1:0] m2_c;
  vtx_t              m2_vtx;
  logic [1:0]        m2_st;
  vtx_t              m2n_vtx;
  logic [1:0]        m2n_st;
  logic              m2n_tri;

  logic              o_v;
  logic              o_tri;
  logic [2:0][EW-1:0] o_c;
  vtx_t              o_vtx;
  logic [1:0]        o_st;
  logic [1:0]        o_idx;

  assign adv  = !o_v || (res.ready && (!o_tri || o_idx == LAST_IDX));
  assign pop  = adv && head_valid;
  assign ring = cfg.slices + 7'd1;
  assign d1_den = head.kind == K_VERT ? DIV_DW'(ring) : DIV_DW'(cfg.slices);
  assign rad  = $signed({1'b0, cfg.radius});

  uvs_div u_div_rc (
    .clk (clk), .en (adv), .num (DIV_NW'(head.num)), .den (d1_den),
    .quo (d1_quo), .rem (d1_rem)
  );

  always_comb begin
    row0  = d1_quo[6:0];
    col   = d1_rem[6:0];
    row   = row0 + 7'd1;
    aprod = 14'(row0) * 14'(ring);
    ca    = 13'd1 + EW'(aprod) + EW'(col);
    cb    = ca + EW'(ring);
    p1_n  = d1_s[DIV_QW-1];
    if (p1_n.kind == K_BAND) begin
      p1_n.corner[0] = p1_n.odd ? cb : ca;
      p1_n.corner[1] = ca + 13'd1;
      p1_n.corner[2] = p1_n.odd ? cb + 13'd1 : cb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_s[0] <= head;
      for (int j = 1; j < DIV_QW; j++) d1_s[j] <= d1_s[j-1];
      p1_s      <= p1_n;
      p1_num[0] <= (DIV_NW'(row) << 16) + DIV_NW'(cfg.stacks);
      p1_den[0] <= {cfg.stacks, 1'b0};
      p1_num[1] <= (DIV_NW'(col) << 16) + DIV_NW'(cfg.slices >> 1);
      p1_den[1] <= DIV_DW'(cfg.slices);
      p1_num[2] <= (DIV_NW'(col) << FRAC_BITS) + DIV_NW'(cfg.slices >> 1);
      p1_den[2] <= DIV_DW'(cfg.slices);
      p1_num[3] <= (DIV_NW'(row) << FRAC_BITS) + DIV_NW'(cfg.stacks >> 1);
      p1_den[3] <= DIV_DW'(cfg.stacks);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_ang
    uvs_div u_div (
      .clk (clk), .en (adv), .num (p1_num[g]), .den (p1_den[g]),
      .quo (d2_quo[g]), .rem ()
    );
  end

  always_comb begin
    d2_n    = d2_s[DIV_QW-1];
    d2_n.tu = d2_quo[2][14:0];
    d2_n.tv = d2_quo[3][14:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_s[0] <= p1_s;
      for (int j = 1; j < DIV_QW; j++) d2_s[j] <= d2_s[j-1];
      s_s[0] <= d2_n;
      for (int j = 1; j < SIN_LAT; j++) s_s[j] <= s_s[j-1];
    end
  end

  uvs_sin u_sin_p (.clk (clk), .en (adv), .ang (d2_quo[0][15:0]), .val (sp));
  uvs_sin u_cos_p (.clk (clk), .en (adv), .ang (d2_quo[0][15:0] + QTURN), .val (cp));
  uvs_sin u_sin_t (.clk (clk), .en (adv), .ang (d2_quo[1][15:0]), .val (st));
  uvs_sin u_cos_t (.clk (clk), .en (adv), .ang (d2_quo[1][15:0] + QTURN), .val (ct));

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_s <= s_s[SIN_LAT-1];
      nx   <= mulq(sp, ct);
      ny   <= cp;
      nz   <= mulq(sp, st);
      tx   <= -st;
      tz   <= ct;
    end
  end

  always_comb begin
    m2n_vtx = '0;
    m2n_st  = ST_LAST;
    m2n_tri = 1'b0;
    case (m1_s.kind)
      K_VERT: begin
        m2n_vtx.pos_x  = mulq(rad, nx);
        m2n_vtx.pos_y  = mulq(rad, ny);
        m2n_vtx.pos_z  = mulq(rad, nz);
        m2n_vtx.tex_u  = m1_s.tu;
        m2n_vtx.tex_v  = m1_s.tv;
        m2n_vtx.norm_x = nx;
        m2n_vtx.norm_y = ny;
        m2n_vtx.norm_z = nz;
        m2n_vtx.tan_x  = tx;
        m2n_vtx.tan_z  = tz;
      end
      K_TOP: begin
        m2n_vtx.pos_y  = rad;
        m2n_vtx.tex_u  = TEX_HALF;
        m2n_vtx.norm_y = Q_ONE;
        m2n_vtx.tan_x  = Q_ONE;
      end
      K_BOT: begin
        m2n_vtx.pos_y  = -rad;
        m2n_vtx.tex_u  = TEX_HALF;
        m2n_vtx.tex_v  = TEX_ONE;
        m2n_vtx.norm_y = -Q_ONE;
        m2n_vtx.tan_x  = Q_ONE;
      end
      K_CAP, K_BAND: m2n_tri = 1'b1;
      default: m2n_st = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_vtx <= m2n_vtx;
      m2_st  <= m2n_st;
      m2_tri <= m2n_tri;
      m2_c   <= m1_s.corner;
      o_vtx  <= m2_vtx;
      o_st   <= m2_st;
      o_tri  <= m2_tri;
      o_c    <= m2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_QW; j++) begin
        d1_v[j] <= 1'b0;
        d2_v[j] <= 1'b0;
      end
      for (int j = 0; j < SIN_LAT; j++) s_v[j] <= 1'b0;
      p1_v  <= 1'b0;
      m1_v  <= 1'b0;
      m2_v  <= 1'b0;
      o_v   <= 1'b0;
      o_idx <= '0;
    end else if (adv) begin
      d1_v[0] <= head_valid;
      for (int j = 1; j < DIV_QW; j++) d1_v[j] <= d1_v[j-1];
      p1_v    <= d1_v[DIV_QW-1];
      d2_v[0] <= p1_v;
      for (int j = 1; j < DIV_QW; j++) d2_v[j] <= d2_v[j-1];
      s_v[0] <= d2_v[DIV_QW-1];
      for (int j = 1; j < SIN_LAT; j++) s_v[j] <= s_v[j-1];
      m1_v  <= s_v[SIN_LAT-1];
      m2_v  <= m1_v;
      o_v   <= m2_v;
      o_idx <= '0;
    end else if (res.ready) begin
      o_idx <= o_idx + 2'd1;
    end
  end

  always_comb begin
    res.valid = o_v;
    if (o_tri) begin
      res.pos_x      = '0;
      res.pos_y      = '0;
      res.pos_z      = '0;
      res.tex_u      = '0;
      res.tex_v      = '0;
      res.norm_x     = '0;
      res.norm_y     = '0;
      res.norm_z     = '0;
      res.tan_x      = '0;
      res.tan_z      = '0;
      res.vertex_ref = o_c[o_idx];
      res.status     = o_idx == LAST_IDX ? ST_LAST : ST_MORE;
    end else begin
      res.pos_x      = o_vtx.pos_x;
      res.pos_y      = o_vtx.pos_y;
      res.pos_z      = o_vtx.pos_z;
      res.tex_u      = o_vtx.tex_u;
      res.tex_v      = o_vtx.tex_v;
      res.norm_x     = o_vtx.norm_x;
      res.norm_y     = o_vtx.norm_y;
      res.norm_z     = o_vtx.norm_z;
      res.tan_x      = o_vtx.tan_x;
      res.tan_z      = o_vtx.tan_z;
      res.vertex_ref = '0;
      res.status     = o_st;
    end
  end
endmodule

@@ rtl/core/uv_sphere_tessellator_core.sv @@
// UV sphere tessellator core: one request a cycle in while the input queue has
// room, vertex or corner words out. Vertex and invalid requests are taken one per
// cycle while the output port is ready and each gives one word; a triangle request
// gives three words, one per output cycle with the port ready, so a run of triangles
// is paced by the output port. Requests pass the two 17-stage long-division
// pipelines (row and column split, then angles and texture coordinates) and the
// 7-stage sine pipeline. Write the registers only once the block has drained, so
// writes take effect for requests accepted after; the block does not enforce it.
`timescale 1ns / 1ps
module uv_sphere_tessellator_core (
  input  logic                        clk,
  input  logic                        rst,
  uvs_req_if.sink                     req,
  uvs_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uvs_pkg::APB_AW-1:0]  paddr,
  input  logic [uvs_pkg::APB_DW-1:0]  pwdata,
  output logic [uvs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import uvs_pkg::*;

  cfg_t  cfg;
  logic  fq_push;
  logic  fq_full;
  logic  fq_pop;
  logic  fq_empty;
  item_t fq_in;
  item_t fq_head;

  uvs_regs u_regs (
    .clk (clk), .rst (rst), .psel (psel), .penable (penable), .pwrite (pwrite),
    .paddr (paddr), .pwdata (pwdata), .prdata (prdata), .pready (pready), .cfg (cfg)
  );

  uvs_front u_front (
    .cfg (cfg), .req (req), .full (fq_full), .push (fq_push), .item (fq_in)
  );

  uvs_fifo u_fifo (
    .clk (clk), .rst (rst), .push (fq_push), .din (fq_in), .full (fq_full),
    .pop (fq_pop), .dout (fq_head), .empty (fq_empty)
  );

  uvs_back u_back (
    .clk (clk), .rst (rst), .cfg (cfg), .head_valid (!fq_empty), .head (fq_head),
    .pop (fq_pop), .res (res)
  );
endmodule

@@ rtl/core/uvs_checker.sv @@
// Port checker for the tessellator core and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module uvs_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic signed [15:0]     res_pos_x,
  input logic signed [15:0]     res_pos_y,
  input logic [14:0]            res_tex_u,
  input logic [14:0]            res_tex_v,
  input logic signed [15:0]     res_norm_y,
  input logic signed [15:0]     res_tan_x,
  input logic [uvs_pkg::EW-1:0] res_vertex_ref,
  input logic [1:0]             res_status
);
  import uvs_pkg::*;

  `UVS_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !res_valid)
  `UVS_ASSERT(a_hold, res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_vertex_ref))
  `UVS_ASSERT(a_invalid_zero, res_valid && res_status == ST_INVALID |-> res_vertex_ref == '0 && res_pos_y == '0 && res_tex_u == '0 && res_norm_y == '0 && res_tan_x == '0)
  `UVS_ASSERT(a_corner_only, res_valid && res_status == ST_MORE |-> res_pos_x == '0 && res_tex_v == '0 && res_norm_y == '0 && res_tan_x == '0)
endmodule

bind uv_sphere_tessellator_core uvs_checker u_chk (
  .clk (clk), .rst (rst), .res_valid (res.valid), .res_ready (res.ready),
  .res_pos_x (res.pos_x), .res_pos_y (res.pos_y), .res_tex_u (res.tex_u),
  .res_tex_v (res.tex_v), .res_norm_y (res.norm_y), .res_tan_x (res.tan_x),
  .res_vertex_ref (res.vertex_ref), .res_status (res.status)
);

@@ tb/uv_sphere_tessellator_core_test.sv @@
// Testbench for the UV sphere tessellator core: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module uv_sphere_tessellator_core_test;
  import uvs_pkg::*;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_z;
    logic [EW-1:0]      vertex_ref;
    logic [1:0]         status;
  } word_t;

  localparam logic CMD_VERTEX   = 1'b0;
  localparam logic CMD_TRIANGLE = 1'b1;
  localparam int   DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  uvs_req_if req ();
  uvs_res_if res ();

  uv_sphere_tessellator_core u_top (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int unsigned stacks_reg, slices_reg, radius_reg;
  word_t expected_words[$];
  int fail_count = 0;
  int hold_off_cycles = 0;
  bit random_stall = 1'b1;

  initial begin
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.element_number = '0;
    res.ready = 1'b0;
  end

  function automatic void queue_word(input word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic longint sin_turn(input int unsigned a);
    int unsigned q;
    longint unsigned t, t2, p, v;
    q = (a >> 14) & 3;
    t = a & 16'h3FFF;
    if (q & 1) t = 16384 - t;
    t2 = (t * t + 8192) >> 14;
    p = 172272;
    p = 5026995 - ((t2 * p + 8192) >> 14);
    p = 85569306 - ((t2 * p + 8192) >> 14);
    p = 693598668 - ((t2 * p + 8192) >> 14);
    p = 1686629713 - ((t2 * p + 8192) >> 14);
    v = (t * p + 8192) >> 14;
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    v = (v + (64'd1 << 15)) >> 16;
    return q >= 2 ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint mul_q14(input longint a, input longint b);
    bit neg;
    longint unsigned ua, ub, m;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    m = (ua * ub + 8192) >> 14;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  task automatic predict_sphere(input logic cmd, input int unsigned e);
    int unsigned stacks, slices, ring, nvert, ntri, nband, k, row, col, aphi, ath, t, qq;
    int unsigned a, b;
    int unsigned c[3];
    longint rad, sp, cp, st, ct, nx, ny, nz;
    word_t w;
    stacks = stacks_reg < 2 ? 2 : (stacks_reg > MAX_STACKS ? MAX_STACKS : stacks_reg);
    slices = slices_reg < 3 ? 3 : (slices_reg > MAX_SLICES ? MAX_SLICES : slices_reg);
    rad = radius_reg > ONE_Q ? ONE_Q : radius_reg;
    ring = slices + 1;
    nvert = 2 + (stacks - 1) * ring;
    ntri = 2 * slices * (stacks - 1);
    nband = 2 * slices * (stacks - 2);
    w = '0;
    if (cmd == CMD_VERTEX) begin
      if (e >= nvert) begin
        w.status = ST_INVALID;
      end else if (e == 0 || e == nvert - 1) begin
        w.pos_y = e == 0 ? rad : -rad;
        w.norm_y = e == 0 ? ONE_Q : -ONE_Q;
        w.tex_u = ONE_Q / 2;
        w.tex_v = e == 0 ? 0 : ONE_Q;
        w.tan_x = ONE_Q;
        w.status = ST_LAST;
      end else begin
        k = e - 1;
        row = k / ring + 1;
        col = k % ring;
        aphi = ((row * 65536 + stacks) / (2 * stacks)) & 16'hFFFF;
        ath = ((col * 65536 + slices / 2) / slices) & 16'hFFFF;
        sp = sin_turn(aphi);
        cp = sin_turn((aphi + 16384) & 16'hFFFF);
        st = sin_turn(ath);
        ct = sin_turn((ath + 16384) & 16'hFFFF);
        nx = mul_q14(sp, ct);
        ny = cp;
        nz = mul_q14(sp, st);
        w.norm_x = nx;
        w.norm_y = ny;
        w.norm_z = nz;
        w.pos_x = mul_q14(rad, nx);
        w.pos_y = mul_q14(rad, ny);
        w.pos_z = mul_q14(rad, nz);
        w.tex_u = (col * ONE_Q + slices / 2) / slices;
        w.tex_v = (row * ONE_Q + stacks / 2) / stacks;
        w.tan_x = -st;
        w.tan_z = ct;
        w.status = ST_LAST;
      end
      queue_word(w);
    end else if (e >= ntri) begin
      w.status = ST_INVALID;
      queue_word(w);
    end else begin
      if (e < slices) begin
        c[0] = 0; c[1] = e + 2; c[2] = e + 1;
      end else if (e - slices < nband) begin
        t = e - slices;
        qq = t >> 1;
        a = 1 + (qq / slices) * ring + qq % slices;
        b = a + ring;
        if ((t & 1) == 0) begin
          c[0] = a; c[1] = a + 1; c[2] = b;
        end else begin
          c[0] = b; c[1] = a + 1; c[2] = b + 1;
        end
      end else begin
        t = e - slices - nband;
        c[0] = nvert - 1; c[1] = nvert - 1 - ring + t; c[2] = nvert - ring + t;
      end
      for (int i = 0; i < 3; i++) begin
        w = '0;
        w.vertex_ref = c[i];
        w.status = i == 2 ? ST_LAST : ST_MORE;
        queue_word(w);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_STACKS: stacks_reg = value & 7'h7F;
      REG_SLICES: slices_reg = value & 7'h7F;
      default: radius_reg = value & 15'h7FFF;
    endcase
  endtask

  task automatic configure_sphere(input int unsigned s, input int unsigned c,
                                  input int unsigned r);
    write_reg(REG_STACKS, s);
    write_reg(REG_SLICES, c);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic send_request(input logic cmd, input int unsigned e, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.element_number <= e;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_sphere(cmd, e);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned vertex_count();
    int unsigned s, c;
    s = stacks_reg < 2 ? 2 : (stacks_reg > MAX_STACKS ? MAX_STACKS : stacks_reg);
    c = slices_reg < 3 ? 3 : (slices_reg > MAX_SLICES ? MAX_SLICES : slices_reg);
    return 2 + (s - 1) * (c + 1);
  endfunction

  function automatic int unsigned triangle_count();
    int unsigned s, c;
    s = stacks_reg < 2 ? 2 : (stacks_reg > MAX_STACKS ? MAX_STACKS : stacks_reg);
    c = slices_reg < 3 ? 3 : (slices_reg > MAX_SLICES ? MAX_SLICES : slices_reg);
    return 2 * c * (s - 1);
  endfunction

  always @(posedge clk) begin
    int gap;
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      res.ready <= 1'b0;
    end else if (!random_stall) begin
      res.ready <= 1'b1;
    end else begin
      gap = $urandom_range(0, 16);
      res.ready <= (gap < 9) || ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    word_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.pos_x, res.pos_y, res.pos_z, res.tex_u, res.tex_v, res.norm_x,
              res.norm_y, res.norm_z, res.tan_x, res.tan_z, res.vertex_ref, res.status};
      if (expected_words.size() == 0) begin
        $error("unexpected word status=%0d ref=%0d", got.status, got.vertex_ref);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.pos_x !== want.pos_x) begin
          $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x); fail_count++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y); fail_count++;
        end
        if (got.pos_z !== want.pos_z) begin
          $error("pos_z exp %0d got %0d", want.pos_z, got.pos_z); fail_count++;
        end
        if (got.tex_u !== want.tex_u) begin
          $error("tex_u exp %0d got %0d", want.tex_u, got.tex_u); fail_count++;
        end
        if (got.tex_v !== want.tex_v) begin
          $error("tex_v exp %0d got %0d", want.tex_v, got.tex_v); fail_count++;
        end
        if (got.norm_x !== want.norm_x) begin
          $error("norm_x exp %0d got %0d", want.norm_x, got.norm_x); fail_count++;
        end
        if (got.norm_y !== want.norm_y) begin
          $error("norm_y exp %0d got %0d", want.norm_y, got.norm_y); fail_count++;
        end
        if (got.norm_z !== want.norm_z) begin
          $error("norm_z exp %0d got %0d", want.norm_z, got.norm_z); fail_count++;
        end
        if (got.tan_x !== want.tan_x) begin
          $error("tan_x exp %0d got %0d", want.tan_x, got.tan_x); fail_count++;
        end
        if (got.tan_z !== want.tan_z) begin
          $error("tan_z exp %0d got %0d", want.tan_z, got.tan_z); fail_count++;
        end
        if (got.vertex_ref !== want.vertex_ref) begin
          $error("vertex_ref exp %0d got %0d", want.vertex_ref, got.vertex_ref); fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    int unsigned nv, nt;
    nv = vertex_count();
    nt = triangle_count();
    send_request(CMD_VERTEX, 0, 1);
    send_request(CMD_VERTEX, nv - 1, 1);
    send_request(CMD_VERTEX, 1, 1);
    send_request(CMD_VERTEX, 21, 1);
    send_request(CMD_VERTEX, nv / 2, 1);
    send_request(CMD_VERTEX, nv, 1);
    send_request(CMD_VERTEX, 8191, 1);
    send_request(CMD_TRIANGLE, 0, 1);
    send_request(CMD_TRIANGLE, 19, 1);
    send_request(CMD_TRIANGLE, 20, 1);
    send_request(CMD_TRIANGLE, 21, 1);
    send_request(CMD_TRIANGLE, nt - 21, 1);
    send_request(CMD_TRIANGLE, nt - 20, 1);
    send_request(CMD_TRIANGLE, nt - 1, 1);
    send_request(CMD_TRIANGLE, nt, 1);
    send_request(CMD_TRIANGLE, 8191, 1);
    wait_drained();
  endtask

  task automatic test_extreme_settings();
    configure_sphere(0, 0, 0);
    send_request(CMD_VERTEX, 0, 1);
    send_request(CMD_VERTEX, 2, 1);
    send_request(CMD_VERTEX, 5, 1);
    send_request(CMD_TRIANGLE, 3, 1);
    send_request(CMD_TRIANGLE, 5, 1);
    send_request(CMD_TRIANGLE, 6, 1);
    wait_drained();
    configure_sphere(127, 127, 15'h7FFF);
    send_request(CMD_VERTEX, vertex_count() - 1, 1);
    send_request(CMD_VERTEX, 100, 1);
    send_request(CMD_TRIANGLE, triangle_count() - 1, 1);
    send_request(CMD_VERTEX, 4000, 1);
    wait_drained();
  endtask

  task automatic random_phase(input int count, input bit gaps);
    int unsigned nv, nt, e;
    logic cmd;
    nv = vertex_count();
    nt = triangle_count();
    repeat (count) begin
      cmd = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: e = $urandom_range(0, 8191);
        1: e = cmd ? nt + $urandom_range(0, 3) : nv + $urandom_range(0, 3);
        default: e = cmd ? $urandom_range(0, nt - 1) : $urandom_range(0, nv - 1);
      endcase
      send_request(cmd, e, gaps);
    end
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      configure_sphere($urandom_range(2, 64), $urandom_range(3, 64), $urandom_range(0, 16384));
      random_phase(50, 1);
      wait_drained();
    end
    configure_sphere(2, 3, 16384);
    random_phase(20, 1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    configure_sphere(20, 20, 8192);
    hold_off_cycles = 300;
    random_phase(40, 0);
    wait_drained();
    random_stall = 1'b0;
    random_phase(20, 0);
    wait_drained();
    random_stall = 1'b1;
  endtask

  initial begin
    stacks_reg = 20;
    slices_reg = 20;
    radius_reg = 8192;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_settings();
    test_random_settings();
    test_backpressure();
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
